>>> src/chained_int_hash_map_top_assert.svh
// Assertion macros shared by the hash map RTL.
`ifndef CHAINED_INT_HASH_MAP_TOP_ASSERT_SVH
`define CHAINED_INT_HASH_MAP_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Holds the sizes, the request kinds, status codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package chm_pkg;
    localparam int BUCKETS = 64;
    localparam int ENTRIES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam logic [6:0] NO_ENTRY = 7'd127;
    localparam logic [6:0] MAX_OUT = 7'd64;

    typedef enum logic [2:0] {
        K_LOOKUP = 3'd0, K_UPDATE = 3'd1, K_STORE = 3'd2, K_SEARCH = 3'd3, K_DUMP = 3'd4
    } t_kind;

    localparam logic [1:0] ST_ABSENT  = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_HEAD, S_CHAIN, S_WALK_B, S_WALK_H, S_WALK_E, S_OUT, S_EMPTY
    } t_state;

    // Divider handshake between the sequencer and the modulo unit.
    typedef struct packed {
        logic        start;
        logic [31:0] mag;
        logic [6:0]  div;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [BW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> src/chm_mod.sv
// ----------------------------------------------------------------------------
// chm_mod: bit-serial modulo unit
// Computes a 32-bit magnitude modulo a 7-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_mod import chm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_num, n_num;
    logic [7:0]  r_rem, n_rem;
    logic [6:0]  r_div, n_div;
    logic        r_done, n_done;
    logic [7:0]  w_sh;

    // One restoring step per cycle, top bit of the magnitude first.
    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_num = r_num; n_rem = r_rem;
        n_div = r_div; n_done = 1'b0;
        w_sh = {r_rem[6:0], r_num[31]};
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = 6'd0; n_num = i_req.mag; n_rem = 8'd0;
            n_div = i_req.div;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem; r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[BW-1:0];
endmodule
`default_nettype wire

>>> src/chained_int_hash_map_top.sv
// ----------------------------------------------------------------------------
// chained_int_hash_map_top: separately chained integer hash map
// Sequencer over a bucket-head memory and an entry memory.
// ----------------------------------------------------------------------------
// One request is taken at a time, and a new one is only accepted once the
// final result of the previous one has been taken. A lookup, update or store
// is accepted, runs through the bit-serial modulo unit, reads the bucket head
// and then reads each chain entry visited from the registered entry memory,
// with a final check when the chain ends without a match, then goes to the
// output state. Search and dump read the head of each bucket walked and then
// each of its entries, and a match waits while the previous result
// transaction is stalled. After reset the bucket heads are swept to empty,
// one per cycle until every bucket is cleared, and no transaction is accepted.
`default_nettype none
`include "chained_int_hash_map_top_assert.svh"
module chained_int_hash_map_top import chm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [31:0]      o_out_key,
    output logic [31:0]      o_out_data,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam logic [1:0] REG_BCOUNT = 2'd0;

    // Memories.
    logic [6:0]  m_head [BUCKETS];
    logic [31:0] m_key  [ENTRIES];
    logic [31:0] m_val  [ENTRIES];
    logic [6:0]  m_next [ENTRIES];

    t_state      r_st, n_st;
    logic [6:0]  r_bcnt;
    logic        r_clr;
    logic [BW:0] r_clr_i;
    logic [6:0]  r_used, n_used;
    t_kind       r_kind, n_kind;
    logic [31:0] r_key, n_key, r_val, n_val;
    logic [BW-1:0] r_b, n_b;
    logic [6:0]  r_e, n_e, r_tail, n_tail;
    logic [6:0]  r_steps, n_steps, r_cnt, n_cnt;
    logic        r_ov, n_ov;
    logic [1:0]  r_ostat, n_ostat;
    logic        r_ofound, n_ofound, r_olast, n_olast;
    logic [31:0] r_okey, n_okey, r_odata, n_odata;
    logic [31:0] r_hkey, n_hkey, r_hdata, n_hdata;
    logic        r_ph, n_ph;
    logic [6:0]  r_rd_head;
    logic [31:0] r_rd_key, r_rd_val;
    logic [6:0]  r_rd_next;
    logic        hw_en, ew_en, vw_en, nw_en;
    logic [BW-1:0] hw_a, hr_a;
    logic [6:0]  hw_d, nw_d;
    logic [EW-1:0] ew_a, vw_a, nw_a, er_a;
    logic [31:0] vw_d;
    logic [6:0]  eff;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;
    logic        acc_in, ev;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_bcnt};
    assign eff = (r_bcnt == 7'd0) ? 7'd1 : (r_bcnt > 7'(BUCKETS)) ? 7'(BUCKETS) : r_bcnt;
    assign o_stall = (r_st != S_IDLE) || r_clr || r_ov;
    assign acc_in = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_status = r_ostat; assign o_found = r_ofound;
    assign o_out_key = r_okey; assign o_out_data = r_odata; assign o_last = r_olast;
    assign ev = (r_e < 7'(ENTRIES)) && (r_e < r_used) && (r_steps < 7'(ENTRIES));

    chm_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Memory ports, registered reads.
    always_ff @(posedge i_clk) begin
        if (hw_en) m_head[hw_a] <= hw_d;
        if (ew_en) m_key[ew_a] <= r_key;
        if (vw_en) m_val[vw_a] <= vw_d;
        if (nw_en) m_next[nw_a] <= nw_d;
        r_rd_head <= m_head[hr_a];
        r_rd_key <= m_key[er_a]; r_rd_val <= m_val[er_a]; r_rd_next <= m_next[er_a];
    end

    // Sequencer.
    always_comb begin
        n_st = r_st; n_used = r_used; n_kind = r_kind; n_key = r_key; n_val = r_val;
        n_b = r_b; n_e = r_e; n_tail = r_tail; n_steps = r_steps; n_cnt = r_cnt;
        n_ov = r_ov; n_ostat = r_ostat; n_ofound = r_ofound; n_olast = r_olast;
        n_okey = r_okey; n_odata = r_odata; n_ph = r_ph;
        n_hkey = r_hkey; n_hdata = r_hdata;
        hw_en = r_clr; hw_a = r_clr_i[BW-1:0]; hw_d = NO_ENTRY;
        ew_en = 1'b0; vw_en = 1'b0; nw_en = 1'b0;
        ew_a = r_used[EW-1:0]; vw_a = r_used[EW-1:0]; vw_d = r_val;
        nw_a = r_used[EW-1:0]; nw_d = NO_ENTRY;
        hr_a = r_b; er_a = r_e[EW-1:0];
        w_dreq.start = 1'b0;
        w_dreq.mag = r_key[31] ? 32'd0 - r_key : r_key;
        w_dreq.div = eff;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (acc_in) begin
                    n_kind = t_kind'(i_kind); n_key = i_key; n_val = i_value;
                    n_steps = '0; n_tail = NO_ENTRY; n_cnt = '0; n_ph = 1'b0;
                    case (i_kind)
                        K_LOOKUP, K_UPDATE, K_STORE: n_st = S_DIV;
                        K_SEARCH, K_DUMP: begin
                            n_b = BW'(eff - 7'd1); n_st = S_WALK_B;
                        end
                        default: begin
                            n_key = '0; n_st = S_EMPTY;
                        end
                    endcase
                end
            end
            S_DIV: begin
                w_dreq.start = !r_ph; n_ph = 1'b1;
                if (w_drsp.done) begin
                    n_b = w_drsp.rem; n_ph = 1'b0; n_st = S_HEAD;
                end
            end
            S_HEAD: begin
                hr_a = r_b;
                if (r_ph) begin
                    n_e = r_rd_head; n_ph = 1'b0; n_st = S_CHAIN;
                end else n_ph = 1'b1;
            end
            S_CHAIN: begin
                if (!r_ph) begin
                    if (ev) n_ph = 1'b1;
                    else begin
                        // Key absent.
                        n_okey = r_key; n_olast = 1'b1; n_st = S_OUT;
                        n_ostat = ST_ABSENT; n_ofound = 1'b0; n_odata = '0;
                        if (r_kind == K_STORE) begin
                            if (r_used >= 7'(ENTRIES)) n_ostat = ST_FULL;
                            else begin
                                n_ofound = 1'b1; n_odata = r_val;
                                ew_en = 1'b1; vw_en = 1'b1; nw_en = 1'b1;
                                n_used = r_used + 7'd1;
                                if (r_tail == NO_ENTRY) begin
                                    hw_en = 1'b1; hw_a = r_b; hw_d = r_used;
                                end
                            end
                        end
                    end
                end else begin
                    n_ph = 1'b0;
                    if (r_rd_key == r_key) begin
                        n_okey = r_key; n_olast = 1'b1; n_st = S_OUT;
                        n_ostat = ST_PRESENT; n_ofound = 1'b1; n_odata = r_rd_val;
                        if (r_kind != K_LOOKUP) begin
                            vw_en = 1'b1; vw_a = r_e[EW-1:0]; n_odata = r_val;
                        end
                    end else begin
                        n_tail = r_e; n_e = r_rd_next; n_steps = r_steps + 7'd1;
                    end
                end
            end
            S_WALK_B: begin
                hr_a = r_b;
                if (r_ph) begin
                    n_e = r_rd_head; n_steps = '0; n_ph = 1'b0; n_st = S_WALK_E;
                end else n_ph = 1'b1;
            end
            S_WALK_E: begin
                if (!r_ph) begin
                    if (ev) n_ph = 1'b1;
                    else if (r_b == '0) begin
                        if (r_cnt == '0) begin
                            n_key = '0; n_st = S_EMPTY;
                        end else begin
                            n_st = S_OUT;
                        end
                    end else begin
                        n_b = r_b - BW'(1); n_st = S_WALK_B;
                    end
                end else if (!r_ov || !i_stall) begin
                    n_ph = 1'b0; n_e = r_rd_next; n_steps = r_steps + 7'd1;
                    if (((r_kind == K_DUMP) || r_rd_val == r_val) && r_cnt < MAX_OUT) begin
                        // The held match goes out once a later one shows it is not the last.
                        if (r_cnt != '0) begin
                            n_ov = 1'b1;
                            n_ostat = ST_PRESENT; n_ofound = 1'b1; n_olast = 1'b0;
                            n_okey = r_hkey; n_odata = r_hdata;
                        end
                        n_cnt = r_cnt + 7'd1;
                        n_hkey = r_rd_key; n_hdata = r_rd_val;
                    end
                end
            end
            S_EMPTY: begin
                n_ostat = ST_ABSENT; n_ofound = 1'b0; n_okey = '0; n_odata = '0;
                n_olast = 1'b1; n_st = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1; n_st = S_IDLE;
                    // The held match of a walk is its final result.
                    if (((r_kind == K_SEARCH) || (r_kind == K_DUMP)) && (r_cnt != '0)) begin
                        n_ostat = ST_PRESENT; n_ofound = 1'b1; n_olast = 1'b1;
                        n_okey = r_hkey; n_odata = r_hdata;
                    end
                end
                // Link a newly stored entry behind the old tail of its chain.
                if ((r_kind == K_STORE) && (r_ostat == ST_ABSENT) && r_ofound
                    && (r_tail != NO_ENTRY)) begin
                    nw_en = 1'b1; nw_a = r_tail[EW-1:0]; nw_d = r_used - 7'd1;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_bcnt <= 7'(BUCKETS); r_used <= '0; r_ov <= 1'b0;
            r_clr <= 1'b1; r_clr_i <= '0; r_ph <= 1'b0;
        end else begin
            r_st <= n_st; r_used <= n_used; r_ov <= n_ov; r_ph <= n_ph;
            if (psel && penable && pwrite && pready && paddr == REG_BCOUNT)
                r_bcnt <= pwdata[6:0];
            if (r_clr) begin
                r_clr_i <= r_clr_i + 1'b1;
                if (r_clr_i == (BW+1)'(BUCKETS - 1)) r_clr <= 1'b0;
            end
        end
        r_kind <= n_kind; r_key <= n_key; r_val <= n_val; r_b <= n_b; r_e <= n_e;
        r_tail <= n_tail; r_steps <= n_steps; r_cnt <= n_cnt;
        r_ostat <= n_ostat; r_ofound <= n_ofound; r_olast <= n_olast;
        r_okey <= n_okey; r_odata <= n_odata;
        r_hkey <= n_hkey; r_hdata <= n_hdata;
    end

    `CHM_ASSERT_IMP(a_no_acc_busy, i_clk, i_rst_n, r_st != S_IDLE, !acc_in)
    `CHM_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= 7'(ENTRIES))
    `CHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_okey))
endmodule
`default_nettype wire
